// ----- rtl/point_to_segment_distance_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef POINT_TO_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_TO_SEGMENT_DISTANCE_MACROS_SVH

// Check a property while reset is low.
`define PTSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define PTSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ptsd_pkg.sv -----
package ptsd_pkg;

   // Clamp choice for the nearest point, decided once dot and length are known.
   typedef struct packed {
      logic pick_start;
      logic pick_end;
   } sel_type;

endpackage

// ----- rtl/point_to_segment_distance.sv -----
// Throughput: one item per cycle while no result is stalled; the restoring divider and the
// square root are unrolled into one register stage per quotient bit and per root bit.
// A stalled result freezes the whole pipeline until it is taken.
// Reset (synchronous, active high) clears every stage valid bit; data registers keep contents.
module point_to_segment_distance
   import ptsd_pkg::*;
#(
   parameter int COORD_BITS      = 20,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [COORD_BITS:0]   rsp_distance,
   output logic signed [COORD_BITS-1:0] rsp_nearest_x,
   output logic signed [COORD_BITS-1:0] rsp_nearest_y
);

   localparam int W    = COORD_BITS;
   localparam int F    = PARAM_FRAC_BITS;
   localparam int DW   = W + 1;           // coordinate difference
   localparam int PW   = 2 * DW;          // product of two differences
   localparam int DOTW = PW + 1;          // signed dot product
   localparam int LENW = PW;              // squared length, unsigned
   localparam int MW   = F + 1 + DW;      // parameter times difference
   localparam int RTW  = W + 1;           // root bits
   localparam int SQW  = 2 * RTW;         // squared distance
   localparam int REMW = RTW + 2;         // root remainder

   logic en;

   // Advance every stage unless a finished result is held back.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // ---------------- stage 1: differences ----------------
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   logic signed [W-1:0]  s1_px_ff, s1_py_ff, s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
      if (en) begin
         s1_a_ff  <= $signed({req_point_x[W-1], req_point_x}) -
                     $signed({req_start_x[W-1], req_start_x});
         s1_b_ff  <= $signed({req_point_y[W-1], req_point_y}) -
                     $signed({req_start_y[W-1], req_start_y});
         s1_c_ff  <= $signed({req_end_x[W-1], req_end_x}) -
                     $signed({req_start_x[W-1], req_start_x});
         s1_d_ff  <= $signed({req_end_y[W-1], req_end_y}) -
                     $signed({req_start_y[W-1], req_start_y});
         s1_px_ff <= req_point_x;
         s1_py_ff <= req_point_y;
         s1_sx_ff <= req_start_x;
         s1_sy_ff <= req_start_y;
         s1_ex_ff <= req_end_x;
         s1_ey_ff <= req_end_y;
      end
   end

   // ---------------- stage 2: products ----------------
   logic                 s2_vld_ff;
   logic signed [PW-1:0] s2_ac_ff, s2_bd_ff, s2_cc_ff, s2_dd_ff;
   logic signed [DW-1:0] s2_c_ff, s2_d_ff;
   logic signed [W-1:0]  s2_px_ff, s2_py_ff, s2_sx_ff, s2_sy_ff, s2_ex_ff, s2_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_ac_ff <= PW'(s1_a_ff) * PW'(s1_c_ff);
         s2_bd_ff <= PW'(s1_b_ff) * PW'(s1_d_ff);
         s2_cc_ff <= PW'(s1_c_ff) * PW'(s1_c_ff);
         s2_dd_ff <= PW'(s1_d_ff) * PW'(s1_d_ff);
         s2_c_ff  <= s1_c_ff;
         s2_d_ff  <= s1_d_ff;
         s2_px_ff <= s1_px_ff;
         s2_py_ff <= s1_py_ff;
         s2_sx_ff <= s1_sx_ff;
         s2_sy_ff <= s1_sy_ff;
         s2_ex_ff <= s1_ex_ff;
         s2_ey_ff <= s1_ey_ff;
      end
   end

   // ---------------- stage 3: dot, length, clamp choice ----------------
   logic signed [DOTW-1:0] dot;
   logic        [LENW-1:0] len;
   sel_type                sel_in;

   always_comb begin
      dot = $signed({s2_ac_ff[PW-1], s2_ac_ff}) + $signed({s2_bd_ff[PW-1], s2_bd_ff});
      len = $unsigned(s2_cc_ff) + $unsigned(s2_dd_ff);
      sel_in.pick_start = (len == '0) || dot[DOTW-1] || (dot == '0);
      sel_in.pick_end   = !sel_in.pick_start &&
                          ($unsigned(dot) >= {{(DOTW-LENW){1'b0}}, len});
   end

   // Divider pipeline: index 0 is stage 3, index k+1 holds quotient bit k.
   logic                 dv_vld_ff [0:F];
   logic [LENW-1:0]      dv_rem_ff [0:F];
   logic [LENW-1:0]      dv_len_ff [0:F];
   logic [F-1:0]         dv_q_ff   [0:F];
   sel_type              dv_sel_ff [0:F];
   logic signed [DW-1:0] dv_c_ff   [0:F];
   logic signed [DW-1:0] dv_d_ff   [0:F];
   logic signed [W-1:0]  dv_px_ff  [0:F];
   logic signed [W-1:0]  dv_py_ff  [0:F];
   logic signed [W-1:0]  dv_sx_ff  [0:F];
   logic signed [W-1:0]  dv_sy_ff  [0:F];
   logic signed [W-1:0]  dv_ex_ff  [0:F];
   logic signed [W-1:0]  dv_ey_ff  [0:F];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (en) begin
         dv_vld_ff[0] <= s2_vld_ff;
      end
      if (en) begin
         dv_rem_ff[0] <= dot[LENW-1:0];
         dv_len_ff[0] <= len;
         dv_q_ff[0]   <= '0;
         dv_sel_ff[0] <= sel_in;
         dv_c_ff[0]   <= s2_c_ff;
         dv_d_ff[0]   <= s2_d_ff;
         dv_px_ff[0]  <= s2_px_ff;
         dv_py_ff[0]  <= s2_py_ff;
         dv_sx_ff[0]  <= s2_sx_ff;
         dv_sy_ff[0]  <= s2_sy_ff;
         dv_ex_ff[0]  <= s2_ex_ff;
         dv_ey_ff[0]  <= s2_ey_ff;
      end
   end

   // One restoring step per stage: shift, compare with length, subtract.
   for (genvar k = 0; k < F; k++) begin : g_div
      logic [LENW:0]   sh;
      logic            ge;
      logic [LENW-1:0] rem_in;
      logic [LENW:0]   diff;

      always_comb begin
         sh     = {dv_rem_ff[k], 1'b0};
         diff   = sh - {1'b0, dv_len_ff[k]};
         ge     = sh >= {1'b0, dv_len_ff[k]};
         rem_in = ge ? diff[LENW-1:0] : sh[LENW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         if (en) begin
            dv_rem_ff[k+1] <= rem_in;
            dv_len_ff[k+1] <= dv_len_ff[k];
            dv_q_ff[k+1]   <= {dv_q_ff[k][F-2:0], ge};
            dv_sel_ff[k+1] <= dv_sel_ff[k];
            dv_c_ff[k+1]   <= dv_c_ff[k];
            dv_d_ff[k+1]   <= dv_d_ff[k];
            dv_px_ff[k+1]  <= dv_px_ff[k];
            dv_py_ff[k+1]  <= dv_py_ff[k];
            dv_sx_ff[k+1]  <= dv_sx_ff[k];
            dv_sy_ff[k+1]  <= dv_sy_ff[k];
            dv_ex_ff[k+1]  <= dv_ex_ff[k];
            dv_ey_ff[k+1]  <= dv_ey_ff[k];
         end
      end
   end

   // ---------------- scale: t times segment vector ----------------
   logic                 sc_vld_ff;
   logic signed [MW-1:0] sc_mx_ff, sc_my_ff;
   sel_type              sc_sel_ff;
   logic signed [W-1:0]  sc_px_ff, sc_py_ff, sc_sx_ff, sc_sy_ff, sc_ex_ff, sc_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff <= 1'b0;
      end else if (en) begin
         sc_vld_ff <= dv_vld_ff[F];
      end
      if (en) begin
         sc_mx_ff  <= MW'($signed({1'b0, dv_q_ff[F]})) * MW'(dv_c_ff[F]);
         sc_my_ff  <= MW'($signed({1'b0, dv_q_ff[F]})) * MW'(dv_d_ff[F]);
         sc_sel_ff <= dv_sel_ff[F];
         sc_px_ff  <= dv_px_ff[F];
         sc_py_ff  <= dv_py_ff[F];
         sc_sx_ff  <= dv_sx_ff[F];
         sc_sy_ff  <= dv_sy_ff[F];
         sc_ex_ff  <= dv_ex_ff[F];
         sc_ey_ff  <= dv_ey_ff[F];
      end
   end

   // ---------------- round and clamp to nearest point ----------------
   localparam logic signed [MW-1:0] HALF = $signed({{(MW-F){1'b0}}, 1'b1, {(F-1){1'b0}}});

   logic signed [MW-1:0] rnd_x, rnd_y, shx, shy;
   logic signed [DW-1:0] sum_x, sum_y;
   logic signed [W-1:0]  nx_in, ny_in;

   always_comb begin
      rnd_x = sc_mx_ff + HALF;
      rnd_y = sc_my_ff + HALF;
      shx   = rnd_x >>> F;
      shy   = rnd_y >>> F;
      sum_x = $signed({sc_sx_ff[W-1], sc_sx_ff}) + $signed(shx[DW-1:0]);
      sum_y = $signed({sc_sy_ff[W-1], sc_sy_ff}) + $signed(shy[DW-1:0]);
      if (sc_sel_ff.pick_start) begin
         nx_in = sc_sx_ff;
         ny_in = sc_sy_ff;
      end else if (sc_sel_ff.pick_end) begin
         nx_in = sc_ex_ff;
         ny_in = sc_ey_ff;
      end else begin
         nx_in = sum_x[W-1:0];
         ny_in = sum_y[W-1:0];
      end
   end

   logic                nr_vld_ff;
   logic signed [W-1:0] nr_nx_ff, nr_ny_ff, nr_px_ff, nr_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_vld_ff <= 1'b0;
      end else if (en) begin
         nr_vld_ff <= sc_vld_ff;
      end
      if (en) begin
         nr_nx_ff <= nx_in;
         nr_ny_ff <= ny_in;
         nr_px_ff <= sc_px_ff;
         nr_py_ff <= sc_py_ff;
      end
   end

   // ---------------- offset, squares, sum ----------------
   logic                 of_vld_ff;
   logic signed [DW-1:0] of_dx_ff, of_dy_ff;
   logic signed [W-1:0]  of_nx_ff, of_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         of_vld_ff <= 1'b0;
      end else if (en) begin
         of_vld_ff <= nr_vld_ff;
      end
      if (en) begin
         of_dx_ff <= $signed({nr_px_ff[W-1], nr_px_ff}) - $signed({nr_nx_ff[W-1], nr_nx_ff});
         of_dy_ff <= $signed({nr_py_ff[W-1], nr_py_ff}) - $signed({nr_ny_ff[W-1], nr_ny_ff});
         of_nx_ff <= nr_nx_ff;
         of_ny_ff <= nr_ny_ff;
      end
   end

   logic                 qd_vld_ff;
   logic signed [PW-1:0] qd_xx_ff, qd_yy_ff;
   logic signed [W-1:0]  qd_nx_ff, qd_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qd_vld_ff <= 1'b0;
      end else if (en) begin
         qd_vld_ff <= of_vld_ff;
      end
      if (en) begin
         qd_xx_ff <= PW'(of_dx_ff) * PW'(of_dx_ff);
         qd_yy_ff <= PW'(of_dy_ff) * PW'(of_dy_ff);
         qd_nx_ff <= of_nx_ff;
         qd_ny_ff <= of_ny_ff;
      end
   end

   // Root pipeline: index 0 holds the squared distance, index RTW the final root.
   logic                rt_vld_ff  [0:RTW];
   logic [SQW-1:0]      rt_n_ff    [0:RTW];
   logic [RTW-1:0]      rt_root_ff [0:RTW];
   logic [REMW-1:0]     rt_rem_ff  [0:RTW];
   logic signed [W-1:0] rt_nx_ff   [0:RTW];
   logic signed [W-1:0] rt_ny_ff   [0:RTW];

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_vld_ff[0] <= 1'b0;
      end else if (en) begin
         rt_vld_ff[0] <= qd_vld_ff;
      end
      if (en) begin
         rt_n_ff[0]    <= $unsigned(qd_xx_ff) + $unsigned(qd_yy_ff);
         rt_root_ff[0] <= '0;
         rt_rem_ff[0]  <= '0;
         rt_nx_ff[0]   <= qd_nx_ff;
         rt_ny_ff[0]   <= qd_ny_ff;
      end
   end

   // One root bit per stage: bring down two bits, try root*4+1, keep if it fits.
   for (genvar j = 0; j < RTW; j++) begin : g_root
      logic [REMW+1:0] sh;
      logic [REMW+1:0] trial;
      logic [REMW+1:0] diff;
      logic            ge;

      always_comb begin
         sh    = {rt_rem_ff[j], rt_n_ff[j][SQW-1-2*j -: 2]};
         trial = {{(REMW-RTW){1'b0}}, rt_root_ff[j], 2'b01};
         diff  = sh - trial;
         ge    = sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            rt_vld_ff[j+1] <= rt_vld_ff[j];
         end
         if (en) begin
            rt_n_ff[j+1]    <= rt_n_ff[j];
            rt_root_ff[j+1] <= {rt_root_ff[j][RTW-2:0], ge};
            rt_rem_ff[j+1]  <= ge ? diff[REMW-1:0] : sh[REMW-1:0];
            rt_nx_ff[j+1]   <= rt_nx_ff[j];
            rt_ny_ff[j+1]   <= rt_ny_ff[j];
         end
      end
   end

   // Drive the result channel from the last root stage.
   assign rsp_valid     = rt_vld_ff[RTW];
   assign rsp_distance  = rt_root_ff[RTW];
   assign rsp_nearest_x = rt_nx_ff[RTW];
   assign rsp_nearest_y = rt_ny_ff[RTW];

endmodule

// ----- rtl/ptsd_check.sv -----
`include "point_to_segment_distance_macros.svh"

module ptsd_check #(
   parameter int COORD_BITS = 20
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic        [COORD_BITS:0]   rsp_distance,
   input logic signed [COORD_BITS-1:0] rsp_nearest_x,
   input logic signed [COORD_BITS-1:0] rsp_nearest_y
);

   // Input is held back only by a result that waits.
   `PTSD_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a blocked result")

   // Reset empties the pipeline.
   `PTSD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

   // A blocked result holds its item.
   `PTSD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_distance) && $stable(rsp_nearest_x) && $stable(rsp_nearest_y)), "blocked result changed")

endmodule

bind point_to_segment_distance ptsd_check #(.COORD_BITS(COORD_BITS)) u_ptsd_check (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_distance  (rsp_distance),
   .rsp_nearest_x (rsp_nearest_x),
   .rsp_nearest_y (rsp_nearest_y)
);
